// ----- rtl/salc_pkg.sv -----
package salc_pkg;

    // Opcodes carried on the input tuser.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;
    localparam int COUNT_W     = 32;
    localparam int WAY_OUT_W   = 3;

    // Outcome of a scan over the ways of one set.
    typedef struct packed {
        logic hit_found;
        logic free_found;
    } scan_status_t;

endpackage

// ----- rtl/salc_row_mem.sv -----
module salc_row_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_W    = 288
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_W-1:0]    wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_W-1:0]    rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/salc_way_scan.sv -----
module salc_way_scan #(
    parameter int WAY_W  = 3,
    parameter int TAG_W  = 32,
    parameter int RANK_W = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  first,
    input  logic [WAY_W-1:0]      idx,
    input  logic                  line_valid,
    input  logic [TAG_W-1:0]      line_tag,
    input  logic [RANK_W-1:0]     line_rank,
    input  logic [TAG_W-1:0]      key_tag,
    output salc_pkg::scan_status_t status,
    output logic [WAY_W-1:0]      hit_way,
    output logic [WAY_W-1:0]      free_way,
    output logic [WAY_W-1:0]      victim_way
);

    logic              hit_found_reg;
    logic              free_found_reg;
    logic [WAY_W-1:0]  hit_way_reg;
    logic [WAY_W-1:0]  free_way_reg;
    logic [WAY_W-1:0]  victim_way_reg;
    logic [RANK_W-1:0] best_rank_reg;
    logic              is_match;

    // The one tag comparator, applied to a single way each cycle.
    assign is_match = line_valid && (line_tag == key_tag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (step_en)
        begin
            hit_found_reg  <= is_match || (!first && hit_found_reg);
            free_found_reg <= !line_valid || (!first && free_found_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (is_match && (first || !hit_found_reg))
            begin
                hit_way_reg <= idx;
            end
            if (!line_valid && (first || !free_found_reg))
            begin
                free_way_reg <= idx;
            end
            // Strictly greater keeps the lowest way among equal ranks.
            if (first || (line_rank > best_rank_reg))
            begin
                best_rank_reg  <= line_rank;
                victim_way_reg <= idx;
            end
        end
    end

    assign status.hit_found  = hit_found_reg;
    assign status.free_found = free_found_reg;
    assign hit_way           = hit_way_reg;
    assign free_way          = free_way_reg;
    assign victim_way        = victim_way_reg;

endmodule

// ----- rtl/set_assoc_lru_cache_sim.sv -----
// A load or store passes the idle, read, scan and update states; the scan visits W ways,
// where W is ways_in_use held to the range 1 to MAX_WAYS, and update registers the result
// once the output is free. A modify then gives its second result from the second-access
// state, which also waits for a free output. No new item is taken until the last is done.
// The single tag comparator visits one way of the set per cycle, and a stalled output adds
// its wait. Reset clears the totals and sets the registers to 4, 4 and 1, then sweeps the
// line store, one set per cycle, before the first item is taken.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: address[31:0]
    input  logic [salc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [salc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: was_hit[0], was_miss[1], was_eviction[2], way_used[5:3],
    // hit_total[37:6], miss_total[69:38], eviction_total[101:70], zero[103:102]
    output logic [salc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tlast: last_of_item
    output logic                                m_axis_tlast
);

    localparam int SET_IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W     = WAY_W;
    localparam int WAYS_CNT_W = $clog2(MAX_WAYS + 1);

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0][RANK_W-1:0]     rank;
        logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
        logic [MAX_WAYS-1:0]                 valid;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_SECOND
    } state_t;

    state_t state_reg;

    logic [3:0]                      set_bits_reg;
    logic [4:0]                      block_bits_reg;
    logic [3:0]                      ways_in_use_reg;

    logic [SET_IDX_W-1:0]            clr_idx_reg;
    logic [1:0]                      op_reg;
    logic [SET_IDX_W-1:0]            set_reg;
    logic [ADDR_WIDTH-1:0]           tag_reg;
    logic [WAY_W-1:0]                idx_reg;
    logic [WAY_W-1:0]                way_reg;

    logic [salc_pkg::COUNT_W-1:0]    hits_reg;
    logic [salc_pkg::COUNT_W-1:0]    misses_reg;
    logic [salc_pkg::COUNT_W-1:0]    evictions_reg;
    logic [salc_pkg::COUNT_W-1:0]    hits_next;
    logic [salc_pkg::COUNT_W-1:0]    misses_next;
    logic [salc_pkg::COUNT_W-1:0]    evictions_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [salc_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            out_last_reg;

    logic [3:0]                      s_eff;
    logic [WAYS_CNT_W-1:0]           ways_eff;
    logic [WAY_W-1:0]                last_idx;
    logic [ADDR_WIDTH-1:0]           addr_w;
    logic [5:0]                      tag_shamt;
    logic [ADDR_WIDTH-1:0]           set_shifted;
    logic [SET_IDX_W-1:0]            set_mask;
    logic [SET_IDX_W-1:0]            set_calc;
    logic [ADDR_WIDTH-1:0]           tag_calc;

    logic                            slot_free;
    logic                            in_accept;

    logic [ROW_W-1:0]                rd_data;
    row_t                            row_q;
    row_t                            new_row;
    logic                            mem_wr_en;
    logic [SET_IDX_W-1:0]            mem_wr_addr;
    logic [ROW_W-1:0]                mem_wr_data;

    salc_pkg::scan_status_t          scan_st;
    logic [WAY_W-1:0]                hit_way;
    logic [WAY_W-1:0]                free_way;
    logic [WAY_W-1:0]                victim_way;
    logic [WAY_W-1:0]                way_sel;
    logic                            evict_now;
    logic [RANK_W-1:0]               old_rank;
    logic                            age_all;

    // Configuration and address split.
    always_comb
    begin
        s_eff = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
        if (ways_in_use_reg == 4'd0)
        begin
            ways_eff = WAYS_CNT_W'(1);
        end
        else if ({1'b0, ways_in_use_reg} > 5'(MAX_WAYS))
        begin
            ways_eff = WAYS_CNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_CNT_W'(ways_in_use_reg);
        end
        last_idx    = WAY_W'(ways_eff - 1'b1);
        addr_w      = ADDR_WIDTH'(s_axis_tdata);
        tag_shamt   = 6'(s_eff) + 6'(block_bits_reg);
        tag_calc    = addr_w >> tag_shamt;
        set_shifted = addr_w >> block_bits_reg;
        set_mask    = ~({SET_IDX_W{1'b1}} << s_eff);
        set_calc    = SET_IDX_W'(set_shifted) & set_mask;
    end

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    salc_row_mem #(
        .ADDR_BITS (SET_IDX_W),
        .DATA_W    (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (set_reg),
        .rd_data (rd_data)
    );

    assign row_q = rd_data;

    salc_way_scan #(
        .WAY_W  (WAY_W),
        .TAG_W  (ADDR_WIDTH),
        .RANK_W (RANK_W)
    ) u_way_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (state_reg == ST_SCAN),
        .first      (idx_reg == '0),
        .idx        (idx_reg),
        .line_valid (row_q.valid[idx_reg]),
        .line_tag   (row_q.tag[idx_reg]),
        .line_rank  (row_q.rank[idx_reg]),
        .key_tag    (tag_reg),
        .status     (scan_st),
        .hit_way    (hit_way),
        .free_way   (free_way),
        .victim_way (victim_way)
    );

    // Way choice and the LRU rank update for one access.
    always_comb
    begin
        if (scan_st.hit_found)
        begin
            way_sel = hit_way;
        end
        else if (scan_st.free_found)
        begin
            way_sel = free_way;
        end
        else
        begin
            way_sel = victim_way;
        end
        evict_now = !scan_st.hit_found && !scan_st.free_found;
        old_rank  = row_q.rank[way_sel];
        age_all   = !row_q.valid[way_sel];
        new_row   = row_q;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if ((WAYS_CNT_W'(i) < ways_eff) && (WAY_W'(i) != way_sel) &&
                (age_all || (row_q.rank[i] < old_rank)) && (row_q.rank[i] < RANK_MAX))
            begin
                new_row.rank[i] = row_q.rank[i] + 1'b1;
            end
        end
        new_row.valid[way_sel] = 1'b1;
        new_row.tag[way_sel]   = tag_reg;
        new_row.rank[way_sel]  = '0;

        hits_next      = hits_reg + (scan_st.hit_found ? 32'd1 : 32'd0);
        misses_next    = misses_reg + (scan_st.hit_found ? 32'd0 : 32'd1);
        evictions_next = evictions_reg + (evict_now ? 32'd1 : 32'd0);
    end

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = set_reg;
        mem_wr_data = new_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_reg;
            mem_wr_data = '0;
        end
        else if ((state_reg == ST_UPDATE) && slot_free)
        begin
            mem_wr_en = 1'b1;
        end
    end

    // The output register empties when taken and fills whenever a result is issued.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (((state_reg == ST_UPDATE) || (state_reg == ST_SECOND)) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 4'd4;
            block_bits_reg  <= 5'd4;
            ways_in_use_reg <= 4'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[3:0];
                salc_pkg::CFG_BLOCK_BITS:  block_bits_reg  <= cfg_wdata;
                salc_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, totals and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            op_reg        <= '0;
            set_reg       <= '0;
            tag_reg       <= '0;
            idx_reg       <= '0;
            way_reg       <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == {SET_IDX_W{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        op_reg    <= s_axis_tuser;
                        set_reg   <= set_calc;
                        tag_reg   <= tag_calc;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (idx_reg == last_idx)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    if (slot_free)
                    begin
                        hits_reg      <= hits_next;
                        misses_reg    <= misses_next;
                        evictions_reg <= evictions_next;
                        way_reg       <= way_sel;
                        out_last_reg  <= (op_reg != salc_pkg::OP_MODIFY);
                        out_data_reg  <= {2'b00, evictions_next, misses_next, hits_next,
                                          salc_pkg::WAY_OUT_W'(way_sel), evict_now,
                                          !scan_st.hit_found, scan_st.hit_found};
                        state_reg     <= (op_reg == salc_pkg::OP_MODIFY) ? ST_SECOND
                                                                         : ST_IDLE;
                    end
                end
                ST_SECOND:
                begin
                    // The second access of a modify finds the line just placed, and
                    // that line already holds the youngest rank.
                    if (slot_free)
                    begin
                        hits_reg      <= hits_reg + 32'd1;
                        out_last_reg  <= 1'b1;
                        out_data_reg  <= {2'b00, evictions_reg, misses_reg,
                                          hits_reg + 32'd1, salc_pkg::WAY_OUT_W'(way_reg),
                                          1'b0, 1'b0, 1'b1};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1] && !m_axis_tdata[0]))
        else $error("eviction reported on an access that did not miss");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new item taken while one is still being worked on");

    a_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SECOND && slot_free) |=>
            (m_axis_tvalid && m_axis_tdata[0] && m_axis_tlast))
        else $error("second access of a modify not reported as a final hit");

    a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (way_sel <= last_idx))
        else $error("chosen way lies beyond the ways in use");

endmodule
